>>> design/sta_pkg.sv
package sta_pkg;

    // Fraction bits of the base-two exponent, which index the power table
    localparam int EXP_TABLE_BITS = 8;
    localparam int TABLE_SIZE     = 1 << EXP_TABLE_BITS;

    localparam int FRONT_STAGES = 8;
    localparam int DIV_BITS     = 17;
    localparam int NSTAGE       = FRONT_STAGES + DIV_BITS + 1;

    localparam int EXP_N_W = 13;
    localparam int TAB_W   = 31;
    localparam int P_W     = 47;
    localparam int E_W     = 62;
    localparam int DEN_W   = 63;

    localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_GAIN  = 2'd0;
    localparam reg_idx_t REG_SLOPE = 2'd1;
    localparam reg_idx_t REG_KNEE  = 2'd2;

    typedef struct packed {
        logic             zero;
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem;
        logic [DIV_BITS-1:0] numlo;
        logic [DIV_BITS-1:0] quo;
    } div_stage_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rest;
        int          i;
        rest = x;
        r    = '0;
        b    = 64'h4000_0000_0000_0000;
        for (i = 0; i < 32; i++) begin
            if (rest >= r + b) begin
                rest = rest - (r + b);
                r    = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(k / 2^EXP_TABLE_BITS) in Q.30, built from repeated square roots of two
    function automatic logic [TAB_W-1:0] exp_table_entry(input int k);
        logic [63:0] roots [EXP_TABLE_BITS+1];
        logic [63:0] acc;
        int          i;
        roots[0] = 64'd1 << 31;
        for (i = 1; i <= EXP_TABLE_BITS; i++) begin
            roots[i] = isqrt64(roots[i-1] << 30);
        end
        acc = 64'd1 << 30;
        for (i = 0; i < EXP_TABLE_BITS; i++) begin
            if (k[i]) begin
                acc = (acc * roots[EXP_TABLE_BITS-i] + (64'd1 << 29)) >> 30;
            end
        end
        return acc[TAB_W-1:0];
    endfunction

endpackage

>>> design/smooth_threshold_activation_top.sv
// Throughput: one request per cycle unless the output stalls; 8 arithmetic stages feed a
// 17-stage restoring divider (one quotient bit per stage) and an output register.
// A stalled output holds only the stages that are full; bubbles still close up.
// Reset (aresetn low, synchronous) clears all valid bits and restores the register defaults.
module smooth_threshold_activation_top
    import sta_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_sample,
    input  logic               s_last_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_response,
    output logic               m_is_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [15:0]        gain_reg;
    logic signed [15:0] slope_reg;
    logic signed [15:0] knee_reg;

    logic [NSTAGE-1:0]  stage_en;
    logic [NSTAGE-1:0]  vld_reg, vld_next;
    logic [NSTAGE-1:0]  last_reg, last_next;
    logic [15:0]        resp_reg, resp_next;
    div_stage_t         front_div, div_out;
    reg_idx_t           reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg  <= 16'd256;
            slope_reg <= 16'sd256;
            knee_reg  <= 16'sd0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_GAIN:  gain_reg  <= pwdata[15:0];
                REG_SLOPE: slope_reg <= pwdata[15:0];
                REG_KNEE:  knee_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_GAIN:  prdata = {16'd0, gain_reg};
            REG_SLOPE: prdata = {16'd0, slope_reg};
            REG_KNEE:  prdata = {16'd0, knee_reg};
            default:   prdata = '0;
        endcase
    end

    // a stage advances unless it and every stage after it are full and the output is stalled
    always_comb begin
        for (int i = 0; i < NSTAGE; i++) begin
            stage_en[i] = m_ready || !(&(vld_reg | ~({NSTAGE{1'b1}} << i)));
        end
    end

    always_comb begin
        for (int i = 0; i < NSTAGE; i++) begin
            if (!stage_en[i]) begin
                vld_next[i]  = vld_reg[i];
                last_next[i] = last_reg[i];
            end else if (i == 0) begin
                vld_next[i]  = s_valid;
                last_next[i] = s_last_in;
            end else begin
                vld_next[i]  = vld_reg[i-1];
                last_next[i] = last_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg <= last_next;
    end

    assign s_ready = stage_en[0];

    sta_front u_front (
        .aclk     (aclk),
        .en_i     (stage_en[FRONT_STAGES-1:0]),
        .sample_i (s_sample),
        .gain_i   (gain_reg),
        .slope_i  (slope_reg),
        .knee_i   (knee_reg),
        .div_o    (front_div)
    );

    sta_div u_div (
        .aclk  (aclk),
        .en_i  (stage_en[FRONT_STAGES +: DIV_BITS]),
        .div_i (front_div),
        .div_o (div_out)
    );

    // a quotient of 65536 means one: saturate
    always_comb begin
        if (div_out.zero) begin
            resp_next = '0;
        end else if (div_out.quo[DIV_BITS-1]) begin
            resp_next = 16'hFFFF;
        end else begin
            resp_next = div_out.quo[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[NSTAGE-1]) begin
            resp_reg <= resp_next;
        end
    end

    assign m_valid    = vld_reg[NSTAGE-1];
    assign m_response = resp_reg;
    assign m_is_last  = last_reg[NSTAGE-1];

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input held off while output drains");

    a_ready_on_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        !(&vld_reg) |-> s_ready)
        else $error("input held off although the pipeline has a free stage");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        ((&vld_reg) && !m_ready) |=> (vld_reg == $past(vld_reg)))
        else $error("full pipeline changed occupancy during output stall");

endmodule

>>> design/sta_front.sv
module sta_front
    import sta_pkg::*;
(
    input  logic                    aclk,
    input  logic [FRONT_STAGES-1:0] en_i,
    input  logic signed [15:0]      sample_i,
    input  logic [15:0]             gain_i,
    input  logic signed [15:0]      slope_i,
    input  logic signed [15:0]      knee_i,
    output div_stage_t              div_o
);

    localparam logic signed [62:0] ROUND = 63'sd1 <<< (49 - EXP_TABLE_BITS);
    localparam logic signed [EXP_N_W-1:0] N_MAX = EXP_N_W'(62);
    localparam int SH_W = P_W + E_W;

    logic [TAB_W-1:0] exp_tab [TABLE_SIZE];

    for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_tab
        assign exp_tab[g] = exp_table_entry(g);
    end

    logic [16:0]                a_mag;
    logic signed [17:0]         d_next, d_reg;
    logic signed [33:0]         z_next, z_reg;
    logic signed [62:0]         u_next, u_reg;
    logic signed [62:0]         w_sum;
    logic signed [EXP_N_W-1:0]  n3_next, n3_reg, n4_reg, n5_reg;
    logic [EXP_TABLE_BITS-1:0]  k_next, k_reg;
    logic [TAB_W-1:0]           t_next, t_reg;
    logic [P_W-1:0]             p_next, p_reg;
    logic [SH_W-1:0]            sh;
    logic [EXP_N_W-1:0]         mag;
    logic [E_W-1:0]             e_next, e_reg;
    logic                       zero_next, zero_reg;
    logic [DEN_W-1:0]           den_w;
    logic [E_W-1:0]             num_w;
    div_stage_t                 div_next, div_reg;

    // magnitude, then distance below the knee
    assign a_mag  = sample_i[15] ? (17'd0 - 17'(sample_i)) : 17'(sample_i);
    assign d_next = 18'(knee_i) - 18'({1'b0, a_mag});

    assign z_next = 34'(slope_i) * 34'(d_reg);
    assign u_next = 63'(z_reg) * 63'(LOG2E_Q30);

    // round to table precision; integer part is the shift, fraction the index
    assign w_sum   = u_reg + ROUND;
    assign n3_next = w_sum[62:50];
    assign k_next  = w_sum[49 -: EXP_TABLE_BITS];

    assign t_next = exp_tab[k_reg];
    assign p_next = P_W'(gain_i) * P_W'(t_reg);

    always_comb begin
        e_next    = '0;
        zero_next = 1'b0;
        sh        = {{E_W{1'b0}}, p_reg} << n5_reg[5:0];
        mag       = EXP_N_W'(-n5_reg);
        if (p_reg != '0) begin
            if (!n5_reg[EXP_N_W-1]) begin
                // exponential too large: response drops to zero
                if ((n5_reg > N_MAX) || (|sh[SH_W-1:E_W])) begin
                    zero_next = 1'b1;
                end else begin
                    e_next = sh[E_W-1:0];
                end
            end else if (mag < EXP_N_W'(P_W)) begin
                e_next = E_W'(p_reg >> mag[5:0]);
            end
        end
    end

    // den/2 split up so both sums come straight from e
    always_comb begin
        den_w = DEN_W'(e_reg) + (DEN_W'(1) << 38);
        num_w = (e_reg >> 1) + (E_W'(1) << 54) + (E_W'(1) << 37);
        div_next.zero  = zero_reg;
        div_next.den   = den_w;
        div_next.rem   = DEN_W'(num_w >> DIV_BITS);
        div_next.numlo = num_w[DIV_BITS-1:0];
        div_next.quo   = '0;
    end

    always_ff @(posedge aclk) begin
        if (en_i[0]) begin
            d_reg <= d_next;
        end
        if (en_i[1]) begin
            z_reg <= z_next;
        end
        if (en_i[2]) begin
            u_reg <= u_next;
        end
        if (en_i[3]) begin
            n3_reg <= n3_next;
            k_reg  <= k_next;
        end
        if (en_i[4]) begin
            t_reg  <= t_next;
            n4_reg <= n3_reg;
        end
        if (en_i[5]) begin
            p_reg  <= p_next;
            n5_reg <= n4_reg;
        end
        if (en_i[6]) begin
            e_reg    <= e_next;
            zero_reg <= zero_next;
        end
        if (en_i[7]) begin
            div_reg <= div_next;
        end
    end

    assign div_o = div_reg;

endmodule

>>> design/sta_div.sv
module sta_div
    import sta_pkg::*;
(
    input  logic                aclk,
    input  logic [DIV_BITS-1:0] en_i,
    input  div_stage_t          div_i,
    output div_stage_t          div_o
);

    div_stage_t st_reg  [DIV_BITS];
    div_stage_t st_next [DIV_BITS];

    // one quotient bit per stage: shift in the next numerator bit, try subtract
    always_comb begin : div_step
        div_stage_t       prev;
        logic [DEN_W:0]   trial;
        logic             ge;
        for (int j = 0; j < DIV_BITS; j++) begin
            if (j == 0) begin
                prev = div_i;
            end else begin
                prev = st_reg[j-1];
            end
            trial = {prev.rem, prev.numlo[DIV_BITS-1]};
            ge    = trial >= {1'b0, prev.den};
            st_next[j].zero  = prev.zero;
            st_next[j].den   = prev.den;
            st_next[j].rem   = ge ? DEN_W'(trial - {1'b0, prev.den}) : trial[DEN_W-1:0];
            st_next[j].numlo = {prev.numlo[DIV_BITS-2:0], 1'b0};
            st_next[j].quo   = {prev.quo[DIV_BITS-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < DIV_BITS; j++) begin
            if (en_i[j]) begin
                st_reg[j] <= st_next[j];
            end
        end
    end

    assign div_o = st_reg[DIV_BITS-1];

endmodule

>>> bench/smooth_threshold_activation_top_tb.sv
`timescale 1ns / 100ps

class response_ledger;
    localparam int     FRAC_BITS = sta_pkg::EXP_TABLE_BITS;
    localparam longint LOG2E_Q30 = 64'sd1549082005;

    typedef struct {
        logic [15:0] response;
        logic        is_last;
    } due_t;

    longint unsigned    exp2_frac [1 << FRAC_BITS];
    logic [15:0]        gain_q8;
    logic signed [15:0] steep_q8;
    logic signed [15:0] knee_q12;
    due_t               due_q [$];
    int unsigned        n_errors;
    int unsigned        n_results;

    function new();
        longint unsigned roots [FRAC_BITS + 1];
        longint unsigned acc;
        int              j;
        int              i;
        // roots[j] is the 2^j-th root of two in Q.30
        roots[0] = 64'd1 << 31;
        for (j = 1; j <= FRAC_BITS; j++) begin
            roots[j] = root_floor(roots[j-1] << 30);
        end
        for (j = 0; j < (1 << FRAC_BITS); j++) begin
            acc = 64'd1 << 30;
            for (i = 0; i < FRAC_BITS; i++) begin
                if (((j >> i) & 1) != 0) begin
                    acc = (acc * roots[FRAC_BITS - i] + (64'd1 << 29)) >> 30;
                end
            end
            exp2_frac[j] = acc;
        end
        gain_q8   = 16'd256;
        steep_q8  = 16'sd256;
        knee_q12  = 16'sd0;
        n_errors  = 0;
        n_results = 0;
    endfunction

    function longint unsigned root_floor(longint unsigned x);
        longint unsigned r;
        longint unsigned trial;
        int              b;
        r = 0;
        for (b = 31; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if (trial * trial <= x) begin
                r = trial;
            end
        end
        return r;
    endfunction

    function void set_register(sta_pkg::reg_idx_t idx, logic [31:0] word);
        case (idx)
            sta_pkg::REG_GAIN: begin
                gain_q8 = word[15:0];
            end
            sta_pkg::REG_SLOPE: begin
                steep_q8 = word[15:0];
            end
            sta_pkg::REG_KNEE: begin
                knee_q12 = word[15:0];
            end
            default: begin
            end
        endcase
    endfunction

    function logic [15:0] threshold_response(logic signed [15:0] smp);
        longint          mag;
        longint          expo_q20;
        longint          expo_q50;
        longint          rounded;
        longint          whole;
        longint unsigned frac_idx;
        longint unsigned mant;
        longint unsigned scaled;
        longint unsigned den;
        longint unsigned quo;
        mag = smp;
        if (mag < 0) begin
            mag = -mag;
        end
        expo_q20 = longint'(steep_q8) * (longint'(knee_q12) - mag);
        // change to base two, then round half up to the table's fraction bits
        expo_q50 = expo_q20 * LOG2E_Q30;
        rounded  = (expo_q50 + (64'sd1 <<< (49 - FRAC_BITS))) >>> (50 - FRAC_BITS);
        whole    = rounded >>> FRAC_BITS;
        frac_idx = rounded & ((64'sd1 <<< FRAC_BITS) - 1);
        mant     = 64'(gain_q8) * exp2_frac[frac_idx];
        if (mant == 0) begin
            scaled = 0;
        end else if (whole >= 0) begin
            // an exponential at or past 2^62 drives the response to zero
            if (whole > 62) begin
                return 16'd0;
            end
            if ((mant >> (62 - whole)) != 0) begin
                return 16'd0;
            end
            scaled = mant << whole;
        end else if (whole <= -64) begin
            scaled = 0;
        end else begin
            scaled = mant >> (-whole);
        end
        den = (64'd1 << 38) + scaled;
        quo = ((64'd1 << 54) + den / 2) / den;
        return (quo > 65535) ? 16'hFFFF : quo[15:0];
    endfunction

    function void note_request(logic [15:0] smp, logic lst);
        due_t want;
        want.response = threshold_response(smp);
        want.is_last  = lst;
        due_q.push_back(want);
    endfunction

    function int pending();
        return due_q.size();
    endfunction

    task report(string what);
        n_errors++;
        if (n_errors <= 100) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    task check_result(logic [15:0] resp, logic lst);
        due_t want;
        n_results++;
        if (due_q.size() == 0) begin
            report($sformatf("unexpected response %0d (last %b)", resp, lst));
            return;
        end
        want = due_q.pop_front();
        if (resp !== want.response) begin
            report($sformatf("response #%0d: got %0d, want %0d",
                             n_results, resp, want.response));
        end
        if (lst !== want.is_last) begin
            report($sformatf("response #%0d: last flag %b, want %b",
                             n_results, lst, want.is_last));
        end
    endtask

    task close_out();
        if (due_q.size() != 0) begin
            report($sformatf("%0d responses never arrived", due_q.size()));
        end
    endtask
endclass

module smooth_threshold_activation_top_tb;
    import sta_pkg::*;

    localparam int       STALL_LIMIT = 2000;
    localparam int       HOLD_CYCLES = 200;
    localparam int       TAIL_CYCLES = 40;
    localparam int       ITEM_TARGET = 1150;
    localparam reg_idx_t REG_SPARE   = 2'd3;

    typedef enum int {
        DRAIN_FREE,
        DRAIN_MOSTLY,
        DRAIN_SPARSE,
        DRAIN_BEAT
    } drain_mode_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_sample;
    logic               s_last_in;
    logic               m_valid;
    logic               m_ready;
    logic [15:0]        m_response;
    logic               m_is_last;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    response_ledger ledger;
    int unsigned    burst_left;
    int unsigned    idle_cycles;
    bit             sender_eager;
    bit             hold_request;
    bit             hold_done;

    smooth_threshold_activation_top u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .s_last_in  (s_last_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_response (m_response),
        .m_is_last  (m_is_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial aclk = 1'b0;

    always #5 aclk = ~aclk;

    task automatic push_sample(logic [15:0] smp, logic lst);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (sender_eager || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_sample  <= smp;
        s_last_in <= lst;
        do @(posedge aclk); while (!s_ready);
        ledger.note_request(smp, lst);
    endtask

    // Upper half of the data word carries junk; only the low 16 bits count.
    task automatic write_reg(reg_idx_t idx, logic [15:0] value);
        logic [31:0] word;
        word = {16'($urandom()), value};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        ledger.set_register(idx, word);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (ledger.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom());
            default: return 16'($urandom_range(32, 1024));
        endcase
    endfunction

    function automatic logic [15:0] pick_slope();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom());
            3: return 16'h0000;
            default: return 16'(int'($urandom_range(0, 4096)) - 2048);
        endcase
    endfunction

    function automatic logic [15:0] pick_knee();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // Half the samples land near the knee, where the response is not yet flat.
    function automatic logic [15:0] pick_sample();
        int mag;
        if ($urandom_range(0, 1) == 0) begin
            return 16'($urandom());
        end
        mag = int'(ledger.knee_q12) + int'($urandom_range(0, 2048)) - 1024;
        return ($urandom_range(0, 1) == 0) ? 16'(mag) : 16'(-mag);
    endfunction

    task automatic random_phase(int unsigned n_items);
        int unsigned i;
        write_reg(REG_GAIN, pick_gain());
        write_reg(REG_SLOPE, pick_slope());
        write_reg(REG_KNEE, pick_knee());
        if ($urandom_range(0, 3) == 0) begin
            write_reg(REG_SPARE, 16'($urandom()));
        end
        sender_eager = ($urandom_range(0, 3) == 0);
        for (i = 0; i < n_items; i++) begin
            push_sample(pick_sample(), $urandom_range(0, 7) == 0);
        end
        settle();
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            ledger.check_result(m_response, m_is_last);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        drain_mode_t mode;
        int unsigned mode_left;
        int unsigned tick;
        m_ready   <= 1'b0;
        mode      = DRAIN_FREE;
        mode_left = 0;
        tick      = 0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_done) begin
                // hold off long enough for the pipeline to fill and block requests
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = drain_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                tick++;
                case (mode)
                    DRAIN_FREE:   m_ready <= 1'b1;
                    DRAIN_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                    DRAIN_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:      m_ready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    initial begin
        int unsigned sent;
        int unsigned phase;
        int unsigned n_items;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_sample     <= '0;
        s_last_in    <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        burst_left   = 0;
        sender_eager = 1'b0;
        hold_request = 1'b0;
        ledger       = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register defaults: zero, both extremes, unit magnitudes, a tiny exponential.
        push_sample(16'h0000, 1'b0);
        push_sample(16'h7FFF, 1'b1);
        push_sample(16'h8000, 1'b0);
        push_sample(16'hFFFF, 1'b1);
        push_sample(16'h0001, 1'b0);
        push_sample(16'h1000, 1'b0);
        push_sample(16'hF000, 1'b1);
        settle();

        // Zero gain: a response of one saturates.
        write_reg(REG_GAIN, 16'h0000);
        push_sample(16'h04D2, 1'b0);
        push_sample(16'h8000, 1'b1);
        settle();

        // Largest gain, steepest slope, highest knee: exponential overflows for a zero sample.
        write_reg(REG_GAIN, 16'hFFFF);
        write_reg(REG_SLOPE, 16'h7FFF);
        write_reg(REG_KNEE, 16'h7FFF);
        push_sample(16'h0000, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7FFF, 1'b1);
        settle();

        // Lowest knee: the exponential vanishes.
        write_reg(REG_KNEE, 16'h8000);
        push_sample(16'h8000, 1'b0);
        settle();

        // Most negative slope turns it back into an overflow.
        write_reg(REG_SLOPE, 16'h8000);
        push_sample(16'h0000, 1'b1);
        push_sample(16'h4000, 1'b0);
        settle();

        // A write to an unmapped register must leave the others alone.
        write_reg(REG_SPARE, 16'h1234);
        push_sample(16'h4000, 1'b1);
        settle();

        sent  = 0;
        phase = 0;
        while (sent < ITEM_TARGET) begin
            n_items = $urandom_range(60, 160);
            if (phase == 2) begin
                hold_request = 1'b1;
                n_items      = 220;
            end
            random_phase(n_items);
            sent += n_items;
            phase++;
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        ledger.close_out();
        if (ledger.n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
